// ===== design/epoch_seconds_to_local_date_assert.svh =====
// assertion macros for the epoch to date converter
`ifndef EPOCH_SECONDS_TO_LOCAL_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_LOCAL_DATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ES2LD_ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("es2ld implication failed");
`define ES2LD_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("es2ld next-cycle check failed");
`else
`define ES2LD_ASSERT_IMPLY(label, clk, rst_n, a, c)
`define ES2LD_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== design/es2ld_pkg.sv =====
`default_nettype none
package es2ld_pkg;

  localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // 2^35 / 675
  localparam logic [31:0] SEC_PER_DAY = 32'd86400;
  localparam logic [15:0] HOUR_RECIP  = 16'd37283;     // 2^27 / 3600
  localparam logic [15:0] CYC_RECIP   = 16'd45934;     // 2^26 / 1461
  localparam logic [16:0] WEEK_RECIP  = 17'd74899;     // 2^19 / 7
  localparam logic [12:0] MIN_RECIP   = 13'd4370;      // 2^18 / 60
  localparam logic [10:0] MOD7_RECIP  = 11'd1171;      // 2^13 / 7
  localparam logic [7:0]  BASE_YEAR   = 8'd70;
  localparam logic [8:0]  BEGIN_DAY   = 9'd119;
  localparam logic [8:0]  END_DAY     = 9'd303;
  localparam logic [8:0]  BEGIN_74    = 9'd5;
  localparam logic [8:0]  END_74      = 9'd333;
  localparam logic [8:0]  BEGIN_75    = 9'd58;
  localparam logic [8:0]  LEAP_SHIFT  = 9'd58;
  localparam logic [7:0]  YEAR_74     = 8'd74;
  localparam logic [7:0]  YEAR_75     = 8'd75;
  localparam logic [31:0] DST_SECS    = 32'd3600;
  localparam logic [4:0]  DST_HOUR_ON = 5'd2;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] mon;
    logic [7:0] year;
    logic [2:0] wday;
    logic [8:0] yday;
  } cal_t;

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/es2ld_conv.sv =====
`default_nettype none
module es2ld_conv
  import es2ld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] secs,
  output cal_t             cal
);

  // stage 1: day reciprocal product
  logic [31:0] s1_r;
  logic [50:0] p1_r;
  // stage 2: days and seconds of day
  logic [15:0] days2_r;
  logic [16:0] rem2_r;
  // stage 3: reciprocal products
  logic [15:0] days3_r;
  logic [16:0] rem3_r;
  logic [32:0] ph3_r;
  logic [31:0] pc3_r;
  logic [33:0] pw3_r;
  // stage 4: hour, four-year cycle, weekday
  logic [4:0]  hour4_r;
  logic [11:0] r24_r;
  logic [5:0]  cyc4_r;
  logic [10:0] rc4_r;
  logic [2:0]  wday4_r;
  // stage 5: year and day of year
  logic [4:0]  hour5_r;
  logic [11:0] r25_r;
  logic [24:0] pm5_r;
  logic [2:0]  wday5_r;
  logic [7:0]  year5_r;
  logic [8:0]  yday5_r;
  logic        leap5_r;
  // stage 6
  cal_t        cal_r;

  logic [15:0] days2_nxt;
  logic [16:0] days_p4;
  logic [4:0]  hour4_nxt;
  logic [5:0]  cyc4_nxt;
  logic [14:0] wq4;
  logic [1:0]  yk;
  logic [10:0] yoff;
  logic [5:0]  min6;
  logic [3:0]  mon6;
  logic [8:0]  mstart;

  always_comb begin
    days2_nxt = p1_r[50:35];
    days_p4   = {1'b0, days3_r} + 17'd4;
    hour4_nxt = ph3_r[31:27];
    cyc4_nxt  = pc3_r[31:26];
    wq4       = pw3_r[33:19];
    if (rc4_r >= 11'd1096) begin
      yk = 2'd3; yoff = 11'd1096;
    end else if (rc4_r >= 11'd730) begin
      yk = 2'd2; yoff = 11'd730;
    end else if (rc4_r >= 11'd365) begin
      yk = 2'd1; yoff = 11'd365;
    end else begin
      yk = 2'd0; yoff = 11'd0;
    end
    min6 = pm5_r[23:18];
    mon6 = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (yday5_r >= month_start(4'(m), leap5_r)) begin
        mon6 = 4'(m);
      end
    end
    mstart = month_start(mon6, leap5_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= secs;
      p1_r    <= 51'(secs[31:7]) * 51'(DAY_RECIP);

      days2_r <= days2_nxt;
      rem2_r  <= 17'(s1_r - 32'(32'(days2_nxt) * SEC_PER_DAY));

      days3_r <= days2_r;
      rem3_r  <= rem2_r;
      ph3_r   <= 33'(rem2_r) * 33'(HOUR_RECIP);
      pc3_r   <= 32'(days2_r) * 32'(CYC_RECIP);
      pw3_r   <= 34'({1'b0, days2_r} + 17'd4) * 34'(WEEK_RECIP);

      hour4_r <= hour4_nxt;
      r24_r   <= 12'(rem3_r - 17'(17'(hour4_nxt) * 17'd3600));
      cyc4_r  <= cyc4_nxt;
      rc4_r   <= 11'(days3_r - 16'(16'(cyc4_nxt) * 16'd1461));
      wday4_r <= 3'(days_p4 - 17'(17'(wq4) * 17'd7));

      hour5_r <= hour4_r;
      r25_r   <= r24_r;
      pm5_r   <= 25'(r24_r) * 25'(MIN_RECIP);
      wday5_r <= wday4_r;
      year5_r <= BASE_YEAR + 8'({cyc4_r, 2'b00}) + 8'(yk);
      yday5_r <= 9'(rc4_r - yoff);
      leap5_r <= (yk == 2'd2);

      cal_r.sec  <= 6'(r25_r - 12'(12'(min6) * 12'd60));
      cal_r.min  <= min6;
      cal_r.hour <= hour5_r;
      cal_r.mon  <= mon6;
      cal_r.mday <= 5'(yday5_r - mstart + 9'd1);
      cal_r.year <= year5_r;
      cal_r.wday <= wday5_r;
      cal_r.yday <= yday5_r;
    end
  end

  assign cal = cal_r;

endmodule
`default_nettype wire

// ===== design/epoch_seconds_to_local_date.sv =====
// Epoch seconds to calendar date converter.
// Input channel: in_valid/in_ready with in_epoch_seconds, unsigned seconds
// since 1970. Output channel: out_valid/out_ready with the broken-down date
// fields and out_is_dst. cfg_we/cfg_wdata write dst_enable (reset value 1);
// write it only while no request is in flight.
// One request can enter every cycle while the output is not stalled: the
// plain and the one-hour-later conversion run side by side in two
// 6-stage date pipelines, followed by a boundary-Sunday stage and a
// select stage that drives the output registers.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Synchronous reset clears all valid bits and sets dst_enable to 1.
`default_nettype none
`include "epoch_seconds_to_local_date_assert.svh"
module epoch_seconds_to_local_date
  import es2ld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_second,
  output logic [5:0]       out_minute,
  output logic [4:0]       out_hour,
  output logic [4:0]       out_month_day,
  output logic [3:0]       out_month,
  output logic [7:0]       out_year_since_1900,
  output logic [2:0]       out_weekday,
  output logic [8:0]       out_year_day,
  output logic             out_is_dst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);

  logic       adv;
  logic [7:0] vld_r;
  logic [7:0] vld_nxt;
  logic       dst_en_r;
  cal_t       cal_a;
  cal_t       cal_b;

  // boundary stage registers
  cal_t       a1_r;
  cal_t       b1_r;
  logic [8:0] db1_r;
  logic [8:0] de1_r;
  logic [10:0] xb1_r;
  logic [10:0] xe1_r;
  logic [21:0] pb1_r;
  logic [21:0] pe1_r;

  cal_t       out_r;
  logic       dst_r;

  logic [8:0]  db_nxt;
  logic [8:0]  de_nxt;
  logic [8:0]  db_raw;
  logic [8:0]  de_raw;
  logic        leap_a;
  logic [10:0] xb_nxt;
  logic [10:0] xe_nxt;
  logic [8:0]  sun_b;
  logic [8:0]  sun_e;
  logic        in_win;

  assign adv      = !vld_r[7] || out_ready;
  assign in_ready = adv;
  assign vld_nxt  = {vld_r[6:0], in_valid};

  es2ld_conv u_conv_plain (
    .clk  (clk),
    .en   (adv),
    .secs (in_epoch_seconds),
    .cal  (cal_a)
  );

  es2ld_conv u_conv_dst (
    .clk  (clk),
    .en   (adv),
    .secs (in_epoch_seconds + DST_SECS),
    .cal  (cal_b)
  );

  always_comb begin
    leap_a = (cal_a.year[1:0] == 2'b00);
    if (cal_a.year == YEAR_74) begin
      db_raw = BEGIN_74; de_raw = END_74;
    end else if (cal_a.year == YEAR_75) begin
      db_raw = BEGIN_75; de_raw = END_DAY;
    end else begin
      db_raw = BEGIN_DAY; de_raw = END_DAY;
    end
    db_nxt = db_raw + 9'((db_raw >= LEAP_SHIFT) && leap_a);
    de_nxt = de_raw + 9'((de_raw >= LEAP_SHIFT) && leap_a);
    xb_nxt = 11'(db_nxt) - 11'(cal_a.yday) + 11'(cal_a.wday) + 11'd700;
    xe_nxt = 11'(de_nxt) - 11'(cal_a.yday) + 11'(cal_a.wday) + 11'd700;

    sun_b = db1_r - 9'(xb1_r - 11'(11'(pb1_r[21:13]) * 11'd7));
    sun_e = de1_r - 9'(xe1_r - 11'(11'(pe1_r[21:13]) * 11'd7));
    in_win = dst_en_r &&
             ((a1_r.yday > sun_b) || (a1_r.yday == sun_b && a1_r.hour >= DST_HOUR_ON)) &&
             ((a1_r.yday < sun_e) || (a1_r.yday == sun_e && a1_r.hour == 5'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      dst_en_r <= 1'b1;
    end else begin
      if (adv) begin
        vld_r <= vld_nxt;
      end
      if (cfg_we) begin
        dst_en_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r  <= cal_a;
      b1_r  <= cal_b;
      db1_r <= db_nxt;
      de1_r <= de_nxt;
      xb1_r <= xb_nxt;
      xe1_r <= xe_nxt;
      pb1_r <= 22'(xb_nxt) * 22'(MOD7_RECIP);
      pe1_r <= 22'(xe_nxt) * 22'(MOD7_RECIP);
      out_r <= in_win ? b1_r : a1_r;
      dst_r <= in_win;
    end
  end

  assign out_valid           = vld_r[7];
  assign out_second          = out_r.sec;
  assign out_minute          = out_r.min;
  assign out_hour            = out_r.hour;
  assign out_month_day       = out_r.mday;
  assign out_month           = out_r.mon;
  assign out_year_since_1900 = out_r.year;
  assign out_weekday         = out_r.wday;
  assign out_year_day        = out_r.yday;
  assign out_is_dst          = dst_r;

  `ES2LD_ASSERT_IMPLY(a_month_range, clk, rst_n, out_valid, out_month <= 4'd11 && out_month_day != 5'd0)
  `ES2LD_ASSERT_IMPLY(a_time_range, clk, rst_n, out_valid, out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59)
  `ES2LD_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_r) && $stable(dst_r))

endmodule
`default_nettype wire
